// File: hw/rtl/dtw_pkg.sv
`default_nettype none

package dtw_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  localparam logic [1:0] OC_CORRECT = 2'd0;
  localparam logic [1:0] OC_ERROR   = 2'd1;
  localparam logic [1:0] OC_SLOW    = 2'd2;

  localparam logic [1:0] CFG_BOUND      = 2'd0;
  localparam logic [1:0] CFG_NOISE_GAIN = 2'd1;
  localparam logic [1:0] CFG_RT_LIMIT   = 2'd2;
  localparam logic [1:0] CFG_STEPS      = 2'd3;

  localparam logic [30:0] BOUND_RST      = 31'd4915200;
  localparam logic [15:0] NOISE_GAIN_RST = 16'd1024;
  localparam logic [16:0] RT_LIMIT_RST   = 17'd40960;
  localparam logic [10:0] STEPS_RST      = 11'd1000;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [30:0] bound;
    logic [15:0] noise_gain;
    logic [16:0] rt_limit;
    logic [10:0] steps_per_trial;
  } cfg_t;

  typedef struct packed {
    logic               is_start;
    logic [10:0]        idx;
    logic signed [33:0] data;      // start point, or table + drift + noise increment
    logic [15:0]        residual;
  } qent_t;

endpackage

`default_nettype wire

// File: hw/rtl/dtw_ram.sv
`default_nettype none

module dtw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dtw_front.sv
`default_nettype none

module dtw_front #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire dtw_pkg::cfg_t             cfg,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_opcode,
  input  wire logic [9:0]                in_table_index,
  input  wire logic signed [31:0]        in_value,
  input  wire logic signed [31:0]        in_trial_drift,
  input  wire logic [15:0]               in_residual_time,
  input  wire logic signed [15:0]        in_noise_sample,
  input  wire logic [dtw_pkg::QCNT_W-1:0] q_count,
  output logic                           q_push,
  output dtw_pkg::qent_t                 q_data
);
  import dtw_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic        active_r;
  logic [10:0] cnt_r;
  logic signed [31:0] drift_r;

  logic               s1_v_r;
  logic               s1_start_r;
  logic [10:0]        s1_idx_r;
  logic signed [31:0] s1_val_r;
  logic [15:0]        s1_res_r;
  logic signed [32:0] s1_prod_r;
  logic               s1_inrange_r;

  logic               acc;
  logic               do_load;
  logic               do_start;
  logic               do_step;
  logic               step_live;
  logic [12:0]        cnt_ext;
  logic [12:0]        tix_ext;
  logic               tix_ok;
  logic               cnt_ok;
  logic [11:0]        cnt_inc;
  logic signed [32:0] prod_nxt;
  logic [31:0]        rdata;
  logic signed [33:0] biased;
  logic signed [33:0] term;
  logic signed [33:0] entry;

  assign in_ready  = (q_count + QCNT_W'(s1_v_r)) < QCNT_W'(QDEPTH);
  assign acc       = in_valid && in_ready;
  assign do_load   = acc && (in_opcode == OP_LOAD);
  assign do_start  = acc && (in_opcode == OP_START);
  assign do_step   = acc && (in_opcode == OP_STEP) && active_r;
  assign step_live = do_step && (cnt_r < cfg.steps_per_trial);

  assign cnt_ext = {2'b00, cnt_r};
  assign tix_ext = {3'b000, in_table_index};
  assign tix_ok  = tix_ext < 13'(TABLE_DEPTH);
  assign cnt_ok  = cnt_ext < 13'(TABLE_DEPTH);
  assign cnt_inc = {1'b0, cnt_r} + 12'd1;

  assign prod_nxt = $signed({1'b0, cfg.noise_gain}) * in_noise_sample;

  dtw_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (do_load && tix_ok),
    .waddr (tix_ext[AW-1:0]),
    .wdata (in_value),
    .re    (step_live),
    .raddr (cnt_ext[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
      s1_v_r   <= 1'b0;
    end else begin
      s1_v_r <= do_start || step_live;
      if (do_start) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (do_step) begin
        if (!step_live) begin
          active_r <= 1'b0;
        end else begin
          cnt_r <= cnt_inc[10:0];
          if (cnt_inc >= {1'b0, cfg.steps_per_trial}) begin
            active_r <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      drift_r <= in_trial_drift;
    end
    if (do_start || step_live) begin
      s1_start_r   <= do_start;
      s1_idx_r     <= cnt_r;
      s1_val_r     <= in_value;
      s1_res_r     <= in_residual_time;
      s1_prod_r    <= prod_nxt;
      s1_inrange_r <= cnt_ok;
    end
  end

  // round half up from q12.20 to q15.16
  assign biased = 34'(s1_prod_r) + 34'sd8;
  assign term   = biased >>> 4;
  assign entry  = s1_inrange_r ? 34'(signed'(rdata)) : 34'sd0;

  always_comb begin
    q_push            = s1_v_r;
    q_data.is_start   = s1_start_r;
    q_data.idx        = s1_idx_r;
    q_data.residual   = s1_res_r;
    if (s1_start_r) begin
      q_data.data = 34'(s1_val_r);
    end else begin
      q_data.data = entry + 34'(drift_r) + term;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dtw_fifo.sv
`default_nettype none

module dtw_fifo (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire dtw_pkg::qent_t             push_data,
  input  wire logic                       pop,
  output dtw_pkg::qent_t                  head,
  output logic                            head_valid,
  output logic [dtw_pkg::QCNT_W-1:0]      count
);
  import dtw_pkg::*;

  qent_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign head       = mem_r[rd_ptr_r];
  assign head_valid = cnt_r != '0;
  assign count      = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < QCNT_W'(QDEPTH)) || pop)
    else $error("word pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("word popped from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

// File: hw/rtl/dtw_back.sv
`default_nettype none

module dtw_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire dtw_pkg::cfg_t  cfg,
  input  wire dtw_pkg::qent_t head,
  input  wire logic           head_valid,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [1:0]          out_outcome,
  output logic [16:0]         out_response_time
);
  import dtw_pkg::*;

  logic signed [31:0] act_r;
  logic [15:0]        res_r;
  logic               decided_r;
  logic               out_v_r;
  logic [1:0]         oc_r;
  logic [16:0]        rt_r;

  logic               out_free;
  logic               live_step;
  logic               new_res;
  logic signed [34:0] sum;
  logic signed [31:0] sat;
  logic signed [32:0] sat_ext;
  logic signed [32:0] bnd;
  logic               cross_hi;
  logic               cross_lo;
  logic [16:0]        rt;
  logic [1:0]         oc;

  assign out_free  = !out_v_r || out_ready;
  assign pop       = head_valid && (head.is_start || decided_r || out_free);
  assign live_step = pop && !head.is_start && !decided_r;

  assign sum = 35'(act_r) + 35'(head.data);

  always_comb begin
    if (sum > 35'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (sum < -35'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = sum[31:0];
    end
  end

  assign sat_ext  = 33'(sat);
  assign bnd      = $signed({2'b00, cfg.bound});
  assign cross_hi = sat_ext > bnd;
  assign cross_lo = sat_ext < -bnd;
  assign new_res  = live_step && (cross_hi || cross_lo);

  assign rt = ((17'(head.idx) + 17'd1) << 4) + 17'(res_r);

  always_comb begin
    if (rt >= cfg.rt_limit) begin
      oc = OC_SLOW;
    end else if (cross_hi) begin
      oc = OC_CORRECT;
    end else begin
      oc = OC_ERROR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= '0;
      res_r     <= '0;
      decided_r <= 1'b1;
      out_v_r   <= 1'b0;
    end else begin
      if (pop && head.is_start) begin
        act_r     <= head.data[31:0];
        res_r     <= head.residual;
        decided_r <= 1'b0;
      end else if (live_step) begin
        act_r <= sat;
        if (new_res) begin
          decided_r <= 1'b1;
        end
      end
      if (new_res) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (new_res) begin
      oc_r <= oc;
      rt_r <= rt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_outcome       = oc_r;
  assign out_response_time = rt_r;

  a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.is_start) |=> !decided_r)
    else $error("start word did not open a trial");

  a_result_closes: assert property (@(posedge clk) disable iff (!rst_n)
    new_res |=> decided_r && out_v_r)
    else $error("crossing did not close the trial");

  a_decided_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (decided_r && !(pop && head.is_start)) |=> decided_r && !new_res)
    else $error("closed trial reopened without start");

endmodule

`default_nettype wire

// File: hw/rtl/drift_diffusion_trial_walker.sv
// drift diffusion trial walker
// input channel (in_*): one word per handshake; opcode selects a drift table
// load, a trial start (start point, trial drift, residual time) or a time step
// carrying one noise sample. load and step words for a table entry must come
// in that order; a table entry is readable from the cycle after its load.
// result channel (out_*): at most one word per trial, outcome and response
// time, emitted on the first boundary crossing.
// config channel (cfg_*): always ready, written while no words are in flight.
// throughput: one input word per cycle, sustained, as long as the result side
// keeps up; the activation update is a single saturating add and compare.
// a crossing step passes the noise multiply stage, then the queue and the
// activation update, which registers the result onto out_valid.
// a 4-entry queue separates the front (table, step counter, multiply) from
// the back (activation); when out_ready is low the back holds its result,
// the queue fills and in_ready drops once it has no room left.
// reset: no trial active, registers take their defaults, table contents
// are undefined until loaded.
`default_nettype none

module drift_diffusion_trial_walker #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [9:0]         in_table_index,
  input  wire logic signed [31:0] in_value,
  input  wire logic signed [31:0] in_trial_drift,
  input  wire logic [15:0]        in_residual_time,
  input  wire logic signed [15:0] in_noise_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_outcome,
  output logic [16:0]             out_response_time
);
  import dtw_pkg::*;

  cfg_t              cfg_r;
  logic              q_push;
  qent_t             q_data;
  logic              q_pop;
  qent_t             q_head;
  logic              q_head_valid;
  logic [QCNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bound           <= BOUND_RST;
      cfg_r.noise_gain      <= NOISE_GAIN_RST;
      cfg_r.rt_limit        <= RT_LIMIT_RST;
      cfg_r.steps_per_trial <= STEPS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BOUND:      cfg_r.bound           <= cfg_data[30:0];
        CFG_NOISE_GAIN: cfg_r.noise_gain      <= cfg_data[15:0];
        CFG_RT_LIMIT:   cfg_r.rt_limit        <= cfg_data[16:0];
        CFG_STEPS:      cfg_r.steps_per_trial <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  dtw_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_table_index   (in_table_index),
    .in_value         (in_value),
    .in_trial_drift   (in_trial_drift),
    .in_residual_time (in_residual_time),
    .in_noise_sample  (in_noise_sample),
    .q_count          (q_count),
    .q_push           (q_push),
    .q_data           (q_data)
  );

  dtw_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid),
    .count      (q_count)
  );

  dtw_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head              (q_head),
    .head_valid        (q_head_valid),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_outcome       (out_outcome),
    .out_response_time (out_response_time)
  );

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dtw_pkg::*;

  // small table so that steps past its end and dropped loads come cheaply
  localparam int TBL_DEPTH = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 8;
  localparam int RX_HOLD = 64;
  localparam int NUM_PHASES = 7;
  localparam longint ACT_MAX = 64'sd2147483647;
  localparam longint ACT_MIN = -64'sd2147483648;

  typedef struct {
    logic [1:0]  outcome;
    logic [16:0] resp_time;
  } crossing_t;

  class walk_scoreboard;
    logic [30:0]        bound;
    logic [15:0]        noise_gain;
    logic [16:0]        rt_limit;
    logic [10:0]        steps_per_trial;
    logic signed [31:0] drift_tbl [TBL_DEPTH];
    bit                 loaded [TBL_DEPTH];
    logic signed [31:0] activation;
    logic [10:0]        step_count;
    bit                 decided;
    logic signed [31:0] held_drift;
    logic [15:0]        held_residual;
    crossing_t          crossings_due [$];
    int                 n_errors;
    int                 n_predicted;
    int                 n_by_outcome [3];

    function new();
      foreach (loaded[i]) loaded[i] = 1'b0;
      activation = '0;
      step_count = '0;
      decided = 1'b1;
      held_drift = '0;
      held_residual = '0;
      bound = BOUND_RST;
      noise_gain = NOISE_GAIN_RST;
      rt_limit = RT_LIMIT_RST;
      steps_per_trial = STEPS_RST;
      n_errors = 0;
      n_predicted = 0;
      foreach (n_by_outcome[i]) n_by_outcome[i] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_BOUND:      bound = data[30:0];
        CFG_NOISE_GAIN: noise_gain = data[15:0];
        CFG_RT_LIMIT:   rt_limit = data[16:0];
        CFG_STEPS:      steps_per_trial = data[10:0];
        default: ;
      endcase
    endfunction

    function bit trial_open();
      return !decided;
    endfunction

    // the next step would read a table entry that was never loaded
    function bit entry_missing();
      return !decided && step_count < steps_per_trial && step_count < TBL_DEPTH &&
             !loaded[step_count];
    endfunction

    function int pending();
      return crossings_due.size();
    endfunction

    function void advance_walk(logic signed [15:0] noise);
      longint    entry;
      longint    prod;
      longint    total;
      longint    lim;
      logic [10:0] idx;
      crossing_t c;
      if (step_count >= steps_per_trial) begin
        decided = 1'b1;
        return;
      end
      entry = (step_count < TBL_DEPTH) ? longint'(drift_tbl[step_count]) : 64'sd0;
      prod = longint'(noise_gain) * longint'(noise);
      // round half up to Q15.16
      total = longint'(activation) + entry + longint'(held_drift) + ((prod + 8) >>> 4);
      if (total > ACT_MAX) total = ACT_MAX;
      if (total < ACT_MIN) total = ACT_MIN;
      activation = 32'(total);
      lim = longint'(bound);
      idx = step_count;
      step_count = step_count + 11'd1;
      if (total > lim || total < -lim) begin
        c.resp_time = 17'((longint'(idx) + 1) * 16 + longint'(held_residual));
        c.outcome = (total > lim) ? OC_CORRECT : OC_ERROR;
        if (c.resp_time >= rt_limit) c.outcome = OC_SLOW;
        crossings_due.insert(crossings_due.size(), c);
        n_predicted++;
        n_by_outcome[c.outcome]++;
        decided = 1'b1;
      end else if (longint'(idx) + 1 >= longint'(steps_per_trial)) begin
        decided = 1'b1;
      end
    endfunction

    function void note_input(logic [1:0] op, logic [9:0] tidx, logic signed [31:0] val,
                             logic signed [31:0] drift, logic [15:0] resid,
                             logic signed [15:0] noise);
      case (op)
        OP_LOAD: begin
          if (tidx < TBL_DEPTH) begin
            drift_tbl[tidx] = val;
            loaded[tidx] = 1'b1;
          end
        end
        OP_START: begin
          activation = val;
          held_drift = drift;
          held_residual = resid;
          step_count = '0;
          decided = 1'b0;
        end
        OP_STEP: begin
          if (!decided) advance_walk(noise);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [1:0] oc, logic [16:0] rt);
      crossing_t c;
      if (crossings_due.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result word, outcome %0d response_time %0d", $time, oc, rt);
        return;
      end
      c = crossings_due.pop_front();
      if (oc !== c.outcome) begin
        n_errors++;
        $display("%0t: outcome expected %0d actual %0d", $time, c.outcome, oc);
      end
      if (rt !== c.resp_time) begin
        n_errors++;
        $display("%0t: response_time expected %0d actual %0d", $time, c.resp_time, rt);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_opcode = '0;
  logic [9:0]         in_table_index = '0;
  logic signed [31:0] in_value = '0;
  logic signed [31:0] in_trial_drift = '0;
  logic [15:0]        in_residual_time = '0;
  logic signed [15:0] in_noise_sample = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_outcome;
  logic [16:0]        out_response_time;

  walk_scoreboard sb = new();
  int     words_sent = 0;
  int     tx_idle_pct = 18;
  int     rx_idle_pct = 87;
  bit     stall_req = 1'b0;
  longint span = longint'(BOUND_RST) / 16 + 1;

  drift_diffusion_trial_walker #(.TABLE_DEPTH(TBL_DEPTH)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_table_index    (in_table_index),
    .in_value          (in_value),
    .in_trial_drift    (in_trial_drift),
    .in_residual_time  (in_residual_time),
    .in_noise_sample   (in_noise_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_outcome       (out_outcome),
    .out_response_time (out_response_time)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: random back-pressure, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        out_ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_outcome, out_response_time);
  end

  function automatic logic signed [31:0] rand_span(longint r);
    return 32'(longint'($urandom) % (2 * r + 1) - r);
  endfunction

  function automatic logic signed [15:0] rand_noise();
    int pick;
    pick = $urandom_range(0, 31);
    case (pick)
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2, 3: return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 6144)) + int'($urandom_range(0, 6144)) - 6144);
    endcase
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [9:0] tidx,
                           input logic signed [31:0] val, input logic signed [31:0] drift,
                           input logic [15:0] resid, input logic signed [15:0] noise);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_table_index <= tidx;
    in_value <= val;
    in_trial_drift <= drift;
    in_residual_time <= resid;
    in_noise_sample <= noise;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(op, tidx, val, drift, resid, noise);
    words_sent++;
    if (words_sent < 300) begin
      tx_idle_pct = 18;
      rx_idle_pct = 87;
    end else if (words_sent < 600) begin
      tx_idle_pct = 87;
      rx_idle_pct = 18;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  task automatic load_word(input logic [9:0] tidx, input logic signed [31:0] val);
    send_word(OP_LOAD, tidx, val, $urandom, 16'($urandom), 16'($urandom));
  endtask

  task automatic start_trial(input logic signed [31:0] val, input logic signed [31:0] drift,
                             input logic [15:0] resid);
    send_word(OP_START, 10'($urandom), val, drift, resid, 16'($urandom));
  endtask

  // a step never reads an entry that was not loaded: fill it first
  task automatic do_step(input logic signed [15:0] noise);
    if (sb.entry_missing()) load_word(10'(sb.step_count), rand_span(span));
    send_word(OP_STEP, 10'($urandom), $urandom, $urandom, 16'($urandom), noise);
  endtask

  task automatic run_trial(input int cap);
    int n;
    n = 0;
    start_trial(rand_span(longint'(sb.bound) / 2), rand_span(span),
                ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255)));
    while (sb.trial_open() && n < cap) begin
      case ($urandom_range(0, 63))
        0: load_word(($urandom_range(0, 3) == 0) ? 10'($urandom)
                                                 : 10'($urandom_range(0, TBL_DEPTH - 1)),
                     ($urandom_range(0, 15) == 0) ? 32'($urandom) : rand_span(span));
        1: send_word(OP_UNUSED, 10'($urandom), $urandom, $urandom, 16'($urandom),
                     16'($urandom));
        2: n = cap;  // abandon, the next start restarts the trial
        default: do_step(rand_noise());
      endcase
      n++;
    end
    if ($urandom_range(0, 3) == 0) do_step(rand_noise());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // unused upper data bits carry noise
  task automatic program_regs(input logic [30:0] b, input logic [15:0] g,
                              input logic [16:0] rl, input logic [10:0] st);
    write_reg(CFG_BOUND, {1'($urandom), b});
    write_reg(CFG_NOISE_GAIN, {16'($urandom), g});
    write_reg(CFG_RT_LIMIT, {15'($urandom), rl});
    write_reg(CFG_STEPS, {21'($urandom), st});
    cfg_valid <= 1'b0;
    span = longint'(b) / 16 + 1;
  endtask

  initial begin : main_seq
    logic [30:0] b;
    logic [15:0] g;
    logic [16:0] rl;
    logic [10:0] st;
    int budget;
    int cap;
    int phase_base;
    int drain;
    int settings_used;
    bit stall_done;
    bit pause_done;
    settings_used = 1;
    stall_done = 1'b0;
    pause_done = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at the reset settings
    do_step(16'sd100);                          // no trial open yet
    send_word(OP_UNUSED, 10'h3FF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
    load_word(10'h3FF, 32'h7FFFFFFF);           // past the table end, dropped
    load_word(10'd0, 32'h7FFFFFFF);
    load_word(10'd1, 32'h80000000);
    start_trial(32'sd0, 32'sd0, 16'hFFFF);
    do_step(16'sh7FFF);                         // saturates high, late response
    do_step(16'sd0);                            // already decided
    start_trial(32'h80000000, 32'h80000000, 16'd0);
    do_step(16'sh8000);                         // saturates low
    load_word(10'd0, 32'sd0);
    start_trial(32'sd0, 32'sd0, 16'd3);
    do_step(16'sd0);
    do_step(16'sh7FFF);                         // table entry 1 pulls it under
    start_trial(32'sd0, 32'sd0, 16'd7);
    do_step(16'sd0);
    start_trial(32'(BOUND_RST), 32'sd1, 16'd0); // restart right on the boundary
    do_step(16'sd0);
    start_trial(32'(-longint'(BOUND_RST)), 32'sd0, 16'd0);
    do_step(16'sd0);                            // exactly -bound is not a crossing
    start_trial(32'h7FFFFFFF, 32'h7FFFFFFF, 16'd0);
    do_step(16'sh7FFF);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin b = 31'd131072; g = 16'd256; rl = 17'd300; st = 11'd40;
                 budget = 200; cap = 60; end
        1: begin b = '0; g = '0; rl = '0; st = '0; budget = 25; cap = 4; end
        2: begin b = '0; g = 16'hFFFF; rl = '0; st = 11'd1; budget = 40; cap = 4; end
        3: begin b = 31'h7FFFFFFF; g = 16'hFFFF; rl = 17'h1FFFF; st = 11'h7FF;
                 budget = 80; cap = 100; end
        4: begin b = 31'd1048576; g = 16'd1024; rl = 17'd2000; st = 11'd1024;
                 budget = 200; cap = 80; end
        default: begin
          b = 31'($urandom_range(1 << 14, 1 << 20));
          g = 16'($urandom_range(64, 2048));
          rl = 17'($urandom_range(0, 2000));
          st = 11'($urandom_range(1, 100));
          budget = 150;
          cap = 60;
        end
      endcase
      wait_drained();
      program_regs(b, g, rl, st);
      settings_used++;
      phase_base = words_sent;
      while (words_sent - phase_base < budget) begin
        run_trial(cap);
        // long result-side hold while words keep coming, then a full drain
        if (p == 0 && !stall_done && words_sent - phase_base > 60) begin
          stall_req = 1'b1;
          stall_done = 1'b1;
        end
        if (p == 0 && !pause_done && words_sent - phase_base > 120) begin
          wait_drained();
          pause_done = 1'b1;
        end
      end
    end

    in_valid <= 1'b0;
    drain = 0;
    while (sb.pending() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d result words never arrived, next expected outcome %0d time %0d",
               $time, sb.pending(), sb.crossings_due[0].outcome,
               sb.crossings_due[0].resp_time);
      sb.n_errors++;
    end

    $display("drove %0d input words under %0d register settings", words_sent, settings_used);
    $display("decisions seen: %0d in all, %0d correct, %0d error, %0d slow", sb.n_predicted,
             sb.n_by_outcome[OC_CORRECT], sb.n_by_outcome[OC_ERROR],
             sb.n_by_outcome[OC_SLOW]);
    if (sb.n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
